// ===== src/cdes_pkg.sv =====
// ----------------------------------------------------------------------------
// cdes_pkg
// Shared constants, types and the month table for the civil date to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package cdes_pkg;

  localparam int Stages = 6;

  localparam int YearWidth   = 14;
  localparam int MonthWidth  = 4;
  localparam int DayWidth    = 5;
  localparam int HourWidth   = 5;
  localparam int MinuteWidth = 6;
  localparam int SecondWidth = 6;
  localparam int InWidth     = 40;
  localparam int OutWidth    = 32;

  localparam int YearsPerEra  = 400;
  localparam int DaysPerEra   = 146097;
  localparam int UnixDayShift = 719468;
  localparam int EpochDays    = 7304;
  localparam int SecsPerDay   = 86400;
  localparam int SecsPerHour  = 3600;
  localparam int SecsPerMin   = 60;

  // Reciprocal of 400 scaled by 2^23, exact for every shifted year in use.
  localparam int EraRecip = 20972;
  localparam int EraShift = 23;
  // Reciprocal of 100 scaled by 2^12, exact below 1024.
  localparam int CentRecip = 41;
  localparam int CentShift = 12;

  // The year is offset by one era so that it never goes negative.
  // The constant also removes that era again, the unix shift, the epoch
  // and the one from day minus one.
  localparam int DayBias = DaysPerEra + UnixDayShift + EpochDays + 1;

  typedef struct packed {
    logic [Stages-1:0] en;
    logic [Stages-1:0] valid;
  } pipe_ctl_t;

  // Days from 1 March to the first of the given month, March based.
  function automatic logic [8:0] month_base(input logic [MonthWidth-1:0] month);
    logic [8:0] base;
    case (month)
      4'd0:    base = 9'd275;
      4'd1:    base = 9'd306;
      4'd2:    base = 9'd337;
      4'd3:    base = 9'd0;
      4'd4:    base = 9'd31;
      4'd5:    base = 9'd61;
      4'd6:    base = 9'd92;
      4'd7:    base = 9'd122;
      4'd8:    base = 9'd153;
      4'd9:    base = 9'd184;
      4'd10:   base = 9'd214;
      4'd11:   base = 9'd245;
      4'd12:   base = 9'd275;
      4'd13:   base = 9'd306;
      4'd14:   base = 9'd337;
      default: base = 9'd367;
    endcase
    return base;
  endfunction

endpackage

// ===== src/cdes_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// cdes_pipe_ctl
// Valid bits and stage enables of the converter pipeline; a stage loads when
// it is empty or when the stage after it loads.
// ----------------------------------------------------------------------------
module cdes_pipe_ctl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output cdes_pkg::pipe_ctl_t ctl
);

  logic [cdes_pkg::Stages-1:0] valid;
  logic [cdes_pkg::Stages-1:0] en;
  logic [cdes_pkg::Stages-1:0] valid_next;

  always_comb begin
    en[cdes_pkg::Stages-1] = !valid[cdes_pkg::Stages-1] || out_ready;
    for (int i = cdes_pkg::Stages - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
    if (en[0]) begin
      valid_next[0] = in_valid;
    end else begin
      valid_next[0] = valid[0];
    end
    for (int i = 1; i < cdes_pkg::Stages; i++) begin
      if (en[i]) begin
        valid_next[i] = valid[i-1];
      end else begin
        valid_next[i] = valid[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready  = en[0];
  assign ctl.en    = en;
  assign ctl.valid = valid;

endmodule

// ===== src/civil_date_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// civil_date_to_epoch_seconds
// Converts a Gregorian date and time of day into seconds since
// 1989-12-31 00:00, wrapped to 32 bits.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while m_tready does not hold the output
// back; six register stages, each with one or two constant multiplies and
// at most a short add chain.
// Reset: synchronous rst clears all stage valid bits; data registers are not
// reset.
module civil_date_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
  // second[39:34]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // seconds_since_epoch[31:0]
  output logic [31:0] m_tdata
);

  cdes_pkg::pipe_ctl_t ctl;

  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        dec;

  logic [14:0] s1_yp;
  logic [8:0]  s1_dp;
  logic [16:0] s1_tod;
  logic [14:0] s2_yp;
  logic [5:0]  s2_era;
  logic [8:0]  s2_dp;
  logic [16:0] s2_tod;
  logic [8:0]  s3_yoe;
  logic [5:0]  s3_era;
  logic [8:0]  s3_dp;
  logic [16:0] s3_tod;
  logic [17:0] s4_doe;
  logic [5:0]  s4_era;
  logic [16:0] s4_tod;
  logic [31:0] s5_days;
  logic [16:0] s5_tod;
  logic [31:0] s6_secs;

  logic [29:0] era_prod;
  logic [17:0] yoe_cent;

  assign year   = s_tdata[13:0];
  assign month  = s_tdata[17:14];
  assign day    = s_tdata[22:18];
  assign hour   = s_tdata[27:23];
  assign minute = s_tdata[33:28];
  assign second = s_tdata[39:34];
  assign dec    = (month <= 4'd2);

  assign era_prod = 30'(s1_yp) * 30'(cdes_pkg::EraRecip);
  assign yoe_cent = 18'(s3_yoe) * 18'(cdes_pkg::CentRecip);

  cdes_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .in_ready  (s_tready),
    .ctl       (ctl)
  );

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_yp  <= 15'(year) + 15'(cdes_pkg::YearsPerEra) - 15'(dec);
      s1_dp  <= cdes_pkg::month_base(month) + 9'(day);
      s1_tod <= 17'(hour) * 17'(cdes_pkg::SecsPerHour)
              + 17'(minute) * 17'(cdes_pkg::SecsPerMin) + 17'(second);
    end
    if (ctl.en[1]) begin
      s2_yp  <= s1_yp;
      s2_era <= 6'(era_prod >> cdes_pkg::EraShift);
      s2_dp  <= s1_dp;
      s2_tod <= s1_tod;
    end
    if (ctl.en[2]) begin
      s3_yoe <= 9'(s2_yp - 15'(s2_era) * 15'(cdes_pkg::YearsPerEra));
      s3_era <= s2_era;
      s3_dp  <= s2_dp;
      s3_tod <= s2_tod;
    end
    if (ctl.en[3]) begin
      s4_doe <= 18'(s3_yoe) * 18'd365 + 18'(s3_yoe[8:2])
              - 18'(yoe_cent >> cdes_pkg::CentShift) + 18'(s3_dp);
      s4_era <= s3_era;
      s4_tod <= s3_tod;
    end
    if (ctl.en[4]) begin
      s5_days <= 32'(s4_era) * 32'(cdes_pkg::DaysPerEra) + 32'(s4_doe)
               - 32'(cdes_pkg::DayBias);
      s5_tod  <= s4_tod;
    end
    if (ctl.en[5]) begin
      s6_secs <= s5_days * 32'(cdes_pkg::SecsPerDay) + 32'(s5_tod);
    end
  end

  assign m_tvalid = ctl.valid[cdes_pkg::Stages-1];
  assign m_tdata  = s6_secs;

endmodule

// ===== src/cdes_checker.sv =====
// ----------------------------------------------------------------------------
// cdes_checker
// Port level checks of the converter: output hold, reset, ready coupling and
// the arrival of an accepted request at the output.
// ----------------------------------------------------------------------------
module cdes_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  logic s_req;

  assign s_req = s_tvalid && s_tready && (s_tdata == s_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed or vanished.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Result valid right after reset.");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("Input stalled while the output drains.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_req ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
    |=> m_tvalid)
    else $error("Request did not reach the output after six cycles.");

endmodule

bind civil_date_to_epoch_seconds cdes_checker u_cdes_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams calendar dates and times through the converter and checks every
// result against a typed-in value or a behavioral day-count model. A short
// table of corner dates goes first, then several hundred random requests with
// bursty input and a stalling output, one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [cdes_pkg::SecondWidth-1:0] second;
    logic [cdes_pkg::MinuteWidth-1:0] minute;
    logic [cdes_pkg::HourWidth-1:0]   hour;
    logic [cdes_pkg::DayWidth-1:0]    day;
    logic [cdes_pkg::MonthWidth-1:0]  month;
    logic [cdes_pkg::YearWidth-1:0]   year;
  } date_time_t;

  typedef struct packed {
    date_time_t                    req;
    logic                          known;
    logic [cdes_pkg::OutWidth-1:0] seconds;
  } date_row_t;

  typedef struct packed {
    date_time_t                    req;
    logic [cdes_pkg::OutWidth-1:0] seconds;
  } seconds_due_t;

  localparam int RandomCount = 400;
  localparam int IdleLimit   = 3000;
  localparam int LongHold    = 100;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [cdes_pkg::InWidth-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [cdes_pkg::OutWidth-1:0] m_tdata;

  // Typed-in expectation that travels beside each request.
  logic                          table_known = 1'b0;
  logic [cdes_pkg::OutWidth-1:0] table_seconds = '0;

  seconds_due_t seconds_due_q[$];
  date_row_t    corner_rows[$];
  int           error_count = 0;
  int           requests_accepted = 0;
  int           results_checked = 0;
  int           input_stall_run = 0;
  int           longest_input_stall = 0;
  int           idle_cycles = 0;
  int           hold_requests = 0;

  always #6 clk = ~clk;

  civil_date_to_epoch_seconds dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Days since 1970-01-01 with a March-based year and floor-divided eras.
  function automatic longint civil_day_count(longint yr, longint mo, longint dy);
    longint y;
    longint era;
    longint yoe;
    longint mp;
    longint doy;
    longint doe;
    y   = yr - ((mo <= 2) ? 1 : 0);
    era = ((y >= 0) ? y : y - (cdes_pkg::YearsPerEra - 1)) / cdes_pkg::YearsPerEra;
    yoe = y - era * cdes_pkg::YearsPerEra;
    mp  = (mo > 2) ? mo - 3 : mo + 9;
    doy = (153 * mp + 2) / 5 + dy - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * cdes_pkg::DaysPerEra + doe - cdes_pkg::UnixDayShift;
  endfunction

  function automatic logic [cdes_pkg::OutWidth-1:0] epoch_seconds(date_time_t d);
    longint days;
    longint total;
    days = civil_day_count(longint'(d.year), longint'(d.month), longint'(d.day))
         - civil_day_count(1989, 12, 31);
    total = days * cdes_pkg::SecsPerDay + longint'(d.hour) * cdes_pkg::SecsPerHour
          + longint'(d.minute) * cdes_pkg::SecsPerMin + longint'(d.second);
    return total[cdes_pkg::OutWidth-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic add_row(int yr, int mo, int dy, int hr, int mi, int se,
                         logic known, logic [cdes_pkg::OutWidth-1:0] seconds);
    date_row_t row;
    row.req.year   = yr[cdes_pkg::YearWidth-1:0];
    row.req.month  = mo[cdes_pkg::MonthWidth-1:0];
    row.req.day    = dy[cdes_pkg::DayWidth-1:0];
    row.req.hour   = hr[cdes_pkg::HourWidth-1:0];
    row.req.minute = mi[cdes_pkg::MinuteWidth-1:0];
    row.req.second = se[cdes_pkg::SecondWidth-1:0];
    row.known      = known;
    row.seconds    = seconds;
    corner_rows.push_back(row);
  endtask

  task automatic offer(date_time_t req, logic known,
                       logic [cdes_pkg::OutWidth-1:0] seconds);
    s_tdata       <= req;
    table_known   <= known;
    table_seconds <= seconds;
    s_tvalid      <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Request and result monitor with the idle watchdog.
  always @(posedge clk) begin
    seconds_due_t due;
    seconds_due_t fresh;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        fresh.req     = date_time_t'(s_tdata);
        fresh.seconds = table_known ? table_seconds : epoch_seconds(fresh.req);
        seconds_due_q.push_back(fresh);
        requests_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (seconds_due_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending", m_tdata));
        end else begin
          due = seconds_due_q.pop_front();
          if (m_tdata !== due.seconds) begin
            report_mismatch($sformatf(
              "%0d-%0d-%0d %0d:%0d:%0d gave seconds %0d, expected %0d",
              due.req.year, due.req.month, due.req.day, due.req.hour,
              due.req.minute, due.req.second, m_tdata, due.seconds));
          end
        end
        results_checked++;
      end
      if (s_tvalid && !s_tready) begin
        input_stall_run++;
        if (input_stall_run > longest_input_stall) begin
          longest_input_stall = input_stall_run;
        end
      end else begin
        input_stall_run = 0;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                   IdleLimit, seconds_due_q.size());
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  // Output side: switches among stall patterns and serves long hold-offs.
  initial begin : receiver
    int mode;
    int left;
    int phase;
    int holds_served;
    int hold_left;
    mode = 0;
    left = 0;
    phase = 0;
    holds_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 64);
        end
        left--;
        phase++;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= (phase % 4) != 0;
          2:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (phase % 8) < 2;
        endcase
      end
    end
  end

  initial begin : stimulus
    date_time_t  req;
    logic [63:0] noise;
    int          burst_left;
    int          gap;
    int          yr;
    int          mo;
    int          dy;
    int          hr;
    int          mi;
    int          se;
    int          dmax;
    bit          leap;

    add_row(1989, 12, 31,  0,  0,  0, 1'b1, 32'd0);
    add_row(1989, 12, 31,  0,  0,  1, 1'b1, 32'd1);
    add_row(1990,  1,  1,  0,  0,  0, 1'b1, 32'd86400);
    add_row(1989, 12, 30,  0,  0,  0, 1'b1, 32'hFFFE_AE80);
    add_row(1970,  1,  1,  0,  0,  0, 1'b1, 32'd3663901696);
    add_row(1989, 12, 31, 23, 59, 60, 1'b1, 32'd86400);
    add_row(   0,  1,  1,  0,  0,  0, 1'b0, '0);
    add_row(   0,  2, 29, 12, 30, 30, 1'b0, '0);
    add_row(   0,  3,  1,  0,  0,  0, 1'b0, '0);
    add_row(2000,  2, 29, 12,  0,  0, 1'b0, '0);
    add_row(2100,  3,  1,  0,  0,  0, 1'b0, '0);
    add_row(1600,  2, 29,  6,  6,  6, 1'b0, '0);
    add_row(9999, 12, 31, 23, 59, 59, 1'b0, '0);
    add_row(2024,  0, 15,  8, 20, 40, 1'b0, '0);
    add_row(2024, 13,  1,  0,  0,  0, 1'b0, '0);
    add_row(2024, 15, 31,  1,  2,  3, 1'b0, '0);
    add_row(2024,  3,  0,  0,  0,  0, 1'b0, '0);
    add_row(2023,  4, 31, 10, 10, 10, 1'b0, '0);
    add_row(2024,  6, 15, 31, 63, 63, 1'b0, '0);
    add_row(16383, 15, 31, 31, 63, 63, 1'b0, '0);
    add_row(   0,  0,  0,  0,  0,  0, 1'b0, '0);
    add_row(2038,  1, 19,  3, 14,  7, 1'b0, '0);
    add_row(2106,  2,  7,  6, 28, 16, 1'b0, '0);
    add_row(1999, 12, 31, 23, 59, 59, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_rows[i]) begin
      offer(corner_rows[i].req, corner_rows[i].known, corner_rows[i].seconds);
    end

    burst_left = 0;
    for (int i = 0; i < RandomCount; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;

      // Hold the output off while requests keep coming so the pipe backs up.
      if (i == 40) begin
        hold_requests++;
        burst_left = 150;
      end
      // Let everything in flight drain before going on.
      if (i == 250) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (seconds_due_q.size() != 0) @(posedge clk);
      end

      if ($urandom_range(0, 4) != 0) begin
        yr   = $urandom_range(0, 9999);
        mo   = $urandom_range(1, 12);
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mo) inside
          2:             dmax = leap ? 29 : 28;
          4, 6, 9, 11:   dmax = 30;
          default:       dmax = 31;
        endcase
        dy = $urandom_range(1, dmax);
        hr = $urandom_range(0, 23);
        mi = $urandom_range(0, 59);
        se = ($urandom_range(0, 30) == 0) ? 60 : $urandom_range(0, 59);
        req.year   = yr[cdes_pkg::YearWidth-1:0];
        req.month  = mo[cdes_pkg::MonthWidth-1:0];
        req.day    = dy[cdes_pkg::DayWidth-1:0];
        req.hour   = hr[cdes_pkg::HourWidth-1:0];
        req.minute = mi[cdes_pkg::MinuteWidth-1:0];
        req.second = se[cdes_pkg::SecondWidth-1:0];
      end else begin
        noise = {$urandom, $urandom};
        req   = noise[cdes_pkg::InWidth-1:0];
      end
      offer(req, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (seconds_due_q.size() != 0) @(posedge clk);
    repeat (cdes_pkg::Stages * 4) @(posedge clk);

    $display("Covered %0d corner dates and %0d random requests, %0d results checked.",
             corner_rows.size(), RandomCount, results_checked);
    $display("Longest input stall %0d cycles, %0d mismatches.",
             longest_input_stall, error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cdes_pkg.sv
src/cdes_pipe_ctl.sv
src/civil_date_to_epoch_seconds.sv
src/cdes_checker.sv
sim/testbench.sv
